// ----- rtl/core/bced_pkg.sv -----
`timescale 1ns / 1ps

package bced_pkg;

    localparam int TIME_BITS_DEFAULT = 16;

    localparam int TICKS_W = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [TICKS_W-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [TICKS_W-1:0] LONG_PRESS_RESET = 16'd1000;
    localparam logic [TICKS_W-1:0] DOUBLE_CLICK_RESET = 16'd400;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE      = 2'd0,
        CFG_LONG_PRESS    = 2'd1,
        CFG_DOUBLE_CLICK  = 2'd2,
        CFG_DOUBLE_ENABLE = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [TICKS_W-1:0] debounce_ticks;
        logic [TICKS_W-1:0] long_press_ticks;
        logic [TICKS_W-1:0] double_click_ticks;
        logic               double_click_enable;
    } t_cfg;

    typedef struct packed {
        logic stable_level;
        logic press_event;
        logic release_event;
        logic click_event;
        logic long_press_event;
        logic double_click_event;
    } t_result;

endpackage

// ----- rtl/core/bced_stream_if.sv -----
`timescale 1ns / 1ps

interface bced_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/button_click_event_detector.sv -----
`timescale 1ns / 1ps

// Debounced button event detector, one request per timebase tick.
// i_in carries the raw active-low pin sample of one tick; o_out returns one
// result per request: the debounced level and one-tick flags for press,
// release, click, long press and double click.
// Thresholds are set through the write port (i_cfg_we, i_cfg_idx,
// i_cfg_data): 0 debounce, 1 long press, 2 double click window,
// 3 double click enable. Write them only while no request is in flight.
// A request is taken into an input register; when the output register is
// free or being emptied, the state update runs on it and its result is
// captured in the output register, where it is held until o_out takes it.
// Throughput is one request per cycle unless o_out stalls. If o_out is
// stalled, the input register still takes one more request, then i_in.ready
// drops until the output register is emptied; nothing is lost or repeated.
// Reset returns the button to released and idle, clears the elapsed-time
// counters, restores the threshold defaults and empties both registers.
module button_click_event_detector #(
    parameter int TIME_BITS = bced_pkg::TIME_BITS_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    bced_stream_if.sink                      i_in,
    bced_stream_if.source                    o_out,
    input  logic                             i_cfg_we,
    input  logic [bced_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bced_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    bced_pkg::t_cfg    cfg;
    bced_pkg::t_result core_result;

    logic              r_in_valid;
    logic              r_in_pin;
    logic              r_out_valid;
    bced_pkg::t_result r_out;
    logic              advance;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    bced_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bced_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_pin    (r_in_pin),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_pin <= i_in.data;
        end
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

// ----- rtl/core/bced_cfg_regs.sv -----
`timescale 1ns / 1ps

module bced_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bced_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bced_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output bced_pkg::t_cfg                     o_cfg
);

    bced_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks      <= bced_pkg::DEBOUNCE_RESET;
            r_cfg.long_press_ticks    <= bced_pkg::LONG_PRESS_RESET;
            r_cfg.double_click_ticks  <= bced_pkg::DOUBLE_CLICK_RESET;
            r_cfg.double_click_enable <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (bced_pkg::t_cfg_idx'(i_cfg_idx))
                bced_pkg::CFG_DEBOUNCE: begin
                    r_cfg.debounce_ticks <= i_cfg_data[bced_pkg::TICKS_W-1:0];
                end
                bced_pkg::CFG_LONG_PRESS: begin
                    r_cfg.long_press_ticks <= i_cfg_data[bced_pkg::TICKS_W-1:0];
                end
                bced_pkg::CFG_DOUBLE_CLICK: begin
                    r_cfg.double_click_ticks <= i_cfg_data[bced_pkg::TICKS_W-1:0];
                end
                bced_pkg::CFG_DOUBLE_ENABLE: begin
                    r_cfg.double_click_enable <= i_cfg_data[0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/bced_core.sv -----
`timescale 1ns / 1ps

module bced_core #(
    parameter int TIME_BITS = bced_pkg::TIME_BITS_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_pin,
    input  bced_pkg::t_cfg      i_cfg,
    output bced_pkg::t_result   o_result
);

    localparam int CMP_W = (TIME_BITS > bced_pkg::TICKS_W) ? TIME_BITS : bced_pkg::TICKS_W;
    localparam logic [TIME_BITS-1:0] TimeMax = '1;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_PRESSED,
        MODE_WAIT_DOUBLE,
        MODE_LONG_SENT
    } t_mode;

    logic                 r_raw_prev, n_raw_prev;
    logic                 r_level, n_level;
    t_mode                r_mode, n_mode;
    logic                 r_second, n_second;
    logic [TIME_BITS-1:0] r_since_raw, n_since_raw;
    logic [TIME_BITS-1:0] r_since_press, n_since_press;
    logic [TIME_BITS-1:0] r_since_rel, n_since_rel;

    logic ev_press, ev_release, ev_click, ev_long, ev_double;

    always_comb begin
        n_raw_prev    = r_raw_prev;
        n_level       = r_level;
        n_mode        = r_mode;
        n_second      = r_second;
        ev_press      = 1'b0;
        ev_release    = 1'b0;
        ev_click      = 1'b0;
        ev_long       = 1'b0;
        ev_double     = 1'b0;

        n_since_raw   = (r_since_raw == TimeMax) ? r_since_raw
                                                 : r_since_raw + TIME_BITS'(1);
        n_since_press = (r_since_press == TimeMax) ? r_since_press
                                                   : r_since_press + TIME_BITS'(1);
        n_since_rel   = (r_since_rel == TimeMax) ? r_since_rel
                                                 : r_since_rel + TIME_BITS'(1);

        if (i_pin != r_raw_prev) begin
            n_raw_prev  = i_pin;
            n_since_raw = '0;
        end

        if ((CMP_W'(n_since_raw) >= CMP_W'(i_cfg.debounce_ticks)) && (i_pin != r_level)) begin
            n_level = i_pin;
            if (!i_pin) begin
                ev_press = 1'b1;
                // A press that follows a release inside the window is the second click.
                if (r_mode == MODE_WAIT_DOUBLE) begin
                    ev_double = 1'b1;
                    n_second  = 1'b1;
                end else begin
                    n_second  = 1'b0;
                end
                n_mode        = MODE_PRESSED;
                n_since_press = '0;
            end else begin
                ev_release  = 1'b1;
                n_since_rel = '0;
                priority if (r_mode == MODE_LONG_SENT) begin
                    n_mode = MODE_IDLE;
                end else if (r_mode == MODE_PRESSED) begin
                    priority if (r_second) begin
                        n_mode = MODE_IDLE;
                    end else if (i_cfg.double_click_enable) begin
                        n_mode = MODE_WAIT_DOUBLE;
                    end else begin
                        ev_click = 1'b1;
                        n_mode   = MODE_IDLE;
                    end
                end else begin
                    n_mode = r_mode;
                end
                n_second = 1'b0;
            end
        end

        if ((n_mode == MODE_PRESSED) && !n_level && !n_second
            && (CMP_W'(n_since_press) >= CMP_W'(i_cfg.long_press_ticks))) begin
            ev_long = 1'b1;
            n_mode  = MODE_LONG_SENT;
        end

        if ((n_mode == MODE_WAIT_DOUBLE)
            && (CMP_W'(n_since_rel) >= CMP_W'(i_cfg.double_click_ticks))) begin
            ev_click = 1'b1;
            n_mode   = MODE_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_prev    <= 1'b1;
            r_level       <= 1'b1;
            r_mode        <= MODE_IDLE;
            r_second      <= 1'b0;
            r_since_raw   <= '0;
            r_since_press <= '0;
            r_since_rel   <= '0;
        end else if (i_step) begin
            r_raw_prev    <= n_raw_prev;
            r_level       <= n_level;
            r_mode        <= n_mode;
            r_second      <= n_second;
            r_since_raw   <= n_since_raw;
            r_since_press <= n_since_press;
            r_since_rel   <= n_since_rel;
        end
    end

    assign o_result.stable_level       = n_level;
    assign o_result.press_event        = ev_press;
    assign o_result.release_event      = ev_release;
    assign o_result.click_event        = ev_click;
    assign o_result.long_press_event   = ev_long;
    assign o_result.double_click_event = ev_double;

endmodule

// ----- rtl/core/bced_checker.sv -----
`timescale 1ns / 1ps

module bced_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_stable_level,
    input logic i_press_event,
    input logic i_release_event,
    input logic i_click_event,
    input logic i_long_press_event,
    input logic i_double_click_event
);

    // The debounced level moves one way per tick and the events agree with it.
    a_edge_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_press_event && i_release_event)
                        && (!i_press_event || !i_stable_level)
                        && (!i_release_event || i_stable_level))
        else $error("press/release flags disagree with the stable level");

    a_double_is_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_double_click_event) |-> i_press_event)
        else $error("double click reported without a press");

    // A long press needs the button held down, so a click cannot share its tick.
    a_long_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_long_press_event) |-> (!i_stable_level && !i_click_event))
        else $error("long press reported while released or with a click");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid
            && $stable({i_stable_level, i_press_event, i_release_event, i_click_event,
                        i_long_press_event, i_double_click_event})))
        else $error("stalled result changed or vanished");

endmodule

bind button_click_event_detector bced_checker u_bced_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_out_valid          (o_out.valid),
    .i_out_ready          (o_out.ready),
    .i_stable_level       (o_out.data.stable_level),
    .i_press_event        (o_out.data.press_event),
    .i_release_event      (o_out.data.release_event),
    .i_click_event        (o_out.data.click_event),
    .i_long_press_event   (o_out.data.long_press_event),
    .i_double_click_event (o_out.data.double_click_event)
);

// ----- tb/button_click_event_detector_tb.sv -----
`timescale 1ns / 1ps

module button_click_event_detector_tb;
    import bced_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_PRESSED,
        MODE_WAIT_SECOND,
        MODE_LONG_SENT
    } t_click_mode;

    localparam int TB_TIME_BITS = TIME_BITS_DEFAULT;
    // Click, double click, a second press held past the long press time,
    // a long press, then a single click closed by the double click window.
    localparam bit [0:20] DIRECTED_PINS = 21'b010000011100001011111;

    // Mirrors the button state and holds the expected results in order.
    class click_scoreboard;
        t_cfg                    cfg;
        logic                    raw_prev;
        logic                    level;
        logic                    second_press;
        t_click_mode             mode;
        logic [TB_TIME_BITS-1:0] since_raw;
        logic [TB_TIME_BITS-1:0] since_press;
        logic [TB_TIME_BITS-1:0] since_release;
        t_result                 expected_q[$];
        int                      errors;

        function new();
            cfg = '{DEBOUNCE_RESET, LONG_PRESS_RESET, DOUBLE_CLICK_RESET, 1'b0};
            raw_prev = 1'b1;
            level = 1'b1;
            second_press = 1'b0;
            mode = MODE_IDLE;
            since_raw = '0;
            since_press = '0;
            since_release = '0;
            errors = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_DEBOUNCE: cfg.debounce_ticks = value;
                CFG_LONG_PRESS: cfg.long_press_ticks = value;
                CFG_DOUBLE_CLICK: cfg.double_click_ticks = value;
                CFG_DOUBLE_ENABLE: cfg.double_click_enable = value[0];
                default: ;
            endcase
        endfunction

        function logic [TB_TIME_BITS-1:0] bump(logic [TB_TIME_BITS-1:0] count);
            return (&count) ? count : count + 1'b1;
        endfunction

        function void note_request(logic pin);
            t_result r;
            r = '0;
            since_raw = bump(since_raw);
            since_press = bump(since_press);
            since_release = bump(since_release);
            if (pin != raw_prev) begin
                raw_prev = pin;
                since_raw = '0;
            end
            if (since_raw >= cfg.debounce_ticks && pin != level) begin
                level = pin;
                if (!pin) begin
                    r.press_event = 1'b1;
                    if (mode == MODE_WAIT_SECOND) begin
                        r.double_click_event = 1'b1;
                        second_press = 1'b1;
                    end else begin
                        second_press = 1'b0;
                    end
                    mode = MODE_PRESSED;
                    since_press = '0;
                end else begin
                    r.release_event = 1'b1;
                    since_release = '0;
                    case (mode)
                        MODE_LONG_SENT: mode = MODE_IDLE;
                        MODE_PRESSED: begin
                            if (second_press) begin
                                mode = MODE_IDLE;
                            end else if (cfg.double_click_enable) begin
                                mode = MODE_WAIT_SECOND;
                            end else begin
                                r.click_event = 1'b1;
                                mode = MODE_IDLE;
                            end
                        end
                        default: ;
                    endcase
                    second_press = 1'b0;
                end
            end
            // The second press of a double click never turns into a long press.
            if (mode == MODE_PRESSED && !level && !second_press &&
                since_press >= cfg.long_press_ticks) begin
                r.long_press_event = 1'b1;
                mode = MODE_LONG_SENT;
            end
            if (mode == MODE_WAIT_SECOND && since_release >= cfg.double_click_ticks) begin
                r.click_event = 1'b1;
                mode = MODE_IDLE;
            end
            r.stable_level = level;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic exp_bit, logic act_bit);
            if (exp_bit !== act_bit) begin
                $error("%s: expected %0b, actual %0b", name, exp_bit, act_bit);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result exp_r;
            if (expected_q.size() == 0) begin
                $error("result arrived with no request outstanding: %b", got);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            compare_field("stable_level", exp_r.stable_level, got.stable_level);
            compare_field("press_event", exp_r.press_event, got.press_event);
            compare_field("release_event", exp_r.release_event, got.release_event);
            compare_field("click_event", exp_r.click_event, got.click_event);
            compare_field("long_press_event", exp_r.long_press_event, got.long_press_event);
            compare_field("double_click_event", exp_r.double_click_event,
                          got.double_click_event);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bced_stream_if #(.T(logic)) req_if ();
    bced_stream_if #(.T(t_result)) res_if ();

    click_scoreboard board = new();

    int idle_pct;
    int stall_pct;
    int hold_left;
    int sent_count;

    button_click_event_detector dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(req_if),
        .o_out(res_if),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else begin
                res_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) board.note_request(req_if.data);
            if (res_if.valid && res_if.ready) board.check_result(res_if.data);
        end
    end

    task automatic send_pin(input logic pin);
        while ($urandom_range(99) < idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data <= pin;
        do @(posedge i_clk); while (!req_if.ready);
        sent_count++;
    endtask

    task automatic send_run(input logic pin, input int count);
        repeat (count) send_pin(pin);
    endtask

    // Short pulses that start on the level given and end on the opposite level, which the following run continues.
    task automatic chatter(input logic to_level, input int pulse_max);
        repeat ($urandom_range(1, 3)) begin
            send_run(to_level, $urandom_range(1, pulse_max));
            send_run(!to_level, $urandom_range(1, pulse_max));
        end
    endtask

    task automatic settle();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(input int deb, input int lp, input int dc, input int en);
        logic [CFG_DATA_W-1:0] vals [4];
        vals[0] = CFG_DATA_W'(deb);
        vals[1] = CFG_DATA_W'(lp);
        vals[2] = CFG_DATA_W'(dc);
        // Only bit 0 of the enable counts; the rest is random filler.
        vals[3] = CFG_DATA_W'(($urandom & 32'hFFFE) | en);
        for (int i = 0; i < 4; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= t_cfg_idx'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            board.set_reg(t_cfg_idx'(i), vals[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Mostly clean press and release runs sized around the thresholds, some noise.
    task automatic click_traffic(input int n_items);
        int target;
        int deb_c;
        int lp_c;
        int dc_c;
        target = sent_count + n_items;
        deb_c = (board.cfg.debounce_ticks > 8) ? 8 : board.cfg.debounce_ticks;
        lp_c = (board.cfg.long_press_ticks > 30) ? 30 : board.cfg.long_press_ticks;
        dc_c = (board.cfg.double_click_ticks > 30) ? 30 : board.cfg.double_click_ticks;
        while (sent_count < target) begin
            if ($urandom_range(99) < 85) begin
                if ($urandom_range(2) == 0) chatter(1'b1, deb_c + 1);
                send_run(1'b0, $urandom_range(1, deb_c + lp_c + 6));
                if ($urandom_range(2) == 0) chatter(1'b0, deb_c + 1);
                send_run(1'b1, $urandom_range(1, deb_c + dc_c + 6));
            end else begin
                repeat ($urandom_range(1, 6)) send_pin(1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        idle_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        sent_count = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_DEBOUNCE;
        i_cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.data = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset thresholds: one press and release past the default debounce.
        send_run(1'b0, 56);
        send_run(1'b1, 56);
        settle();

        configure(0, 3, 2, 1);
        for (int i = 0; i < 21; i++) send_pin(DIRECTED_PINS[i]);
        settle();

        for (int p = 0; p < 14; p++) begin
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 81; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 81; end
                default: begin idle_pct = 25; stall_pct = 25; end
            endcase
            case (p)
                0: configure(0, 65535, 65535, 1);
                1: configure(65535, 0, 0, 0);
                2: configure(0, 0, 0, 1);
                default: configure($urandom_range(0, 4), $urandom_range(0, 30),
                                   $urandom_range(0, 20), $urandom_range(0, 1));
            endcase
            // Hold the output long enough that both registers fill and input stalls.
            if (p == 4) hold_left = 60;
            click_traffic((p == 1) ? 20 : 35);
            settle();
        end

        if (board.errors == 0 && board.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- button_click_event_detector.f -----
rtl/core/bced_pkg.sv
rtl/core/bced_stream_if.sv
rtl/core/bced_cfg_regs.sv
rtl/core/bced_core.sv
rtl/core/button_click_event_detector.sv
rtl/core/bced_checker.sv
tb/button_click_event_detector_tb.sv
